// File: hw/rtl/llp_pkg.sv
package llp_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int STACK_DEPTH   = 64;
    localparam int RULE_MAX_LEN  = 8;

    localparam int TAB_AW = $clog2(TABLE_ENTRIES);
    localparam int STK_AW = $clog2(STACK_DEPTH);
    localparam int SP_W   = $clog2(STACK_DEPTH + 1);
    localparam int LEN_W  = 4;
    localparam int CNT_W  = $clog2(RULE_MAX_LEN + 1);
    localparam int BIDX_W = (RULE_MAX_LEN > 1) ? $clog2(RULE_MAX_LEN) : 1;

    localparam logic [7:0] END_MARK = 8'd36;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_FEED  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;

    localparam logic [2:0] ST_CONSUMED = 3'd0;
    localparam logic [2:0] ST_ACCEPTED = 3'd1;
    localparam logic [2:0] ST_REJECTED = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_EXP_LIM  = 3'd4;
    localparam logic [2:0] ST_STORED   = 3'd5;
    localparam logic [2:0] ST_FULL     = 3'd6;
    localparam logic [2:0] ST_CLEARED  = 3'd7;

    localparam logic REG_START  = 1'b0;
    localparam logic REG_MAXEXP = 1'b1;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  symbol;
        logic [7:0]  rule_nonterminal;
        logic [7:0]  rule_terminal;
        logic [3:0]  rule_length;
        logic [63:0] rule_body;
    } llp_in_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] expansions_used;
        logic [6:0] stack_level;
    } llp_out_t;

    typedef struct packed {
        logic [15:0]      key;
        logic [LEN_W-1:0] len;
        logic [63:0]      body;
    } llp_entry_t;

    typedef struct packed {
        logic              lookup;
        logic              write;
        logic              clear;
        logic [15:0]       key;
        logic [TAB_AW-1:0] widx;
        llp_entry_t        wentry;
    } llp_tab_cmd_t;

    typedef struct packed {
        logic              done;
        logic              found;
        logic [TAB_AW-1:0] hit_idx;
        logic              free_ok;
        logic [TAB_AW-1:0] free_idx;
        llp_entry_t        entry;
    } llp_tab_rsp_t;

endpackage

// File: hw/rtl/llp_ram.sv
module llp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/llp_table.sv
module llp_table (
    input  logic                  clk,
    input  logic                  rst_n,
    input  llp_pkg::llp_tab_cmd_t cmd,
    output llp_pkg::llp_tab_rsp_t rsp
);
    import llp_pkg::*;

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_ADDR = 2'd1;
    localparam logic [1:0] T_CMP  = 2'd2;
    localparam logic [TAB_AW-1:0] LAST_IDX = TAB_AW'(TABLE_ENTRIES - 1);

    logic [1:0]              state_reg, state_next;
    logic [TAB_AW-1:0]       idx_reg, idx_next;
    logic [15:0]             key_reg, key_next;
    logic                    free_ok_reg, free_ok_next;
    logic [TAB_AW-1:0]       free_idx_reg, free_idx_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    llp_entry_t              rdata;
    logic                    re;
    logic                    hit;
    logic                    free_ok_now;
    logic [TAB_AW-1:0]       free_idx_now;

    llp_ram #(
        .WIDTH ($bits(llp_entry_t)),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.write),
        .waddr (cmd.widx),
        .wdata (cmd.wentry),
        .re    (re),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    assign re           = (state_reg == T_ADDR);
    assign hit          = valid_reg[idx_reg] && (rdata.key == key_reg);
    assign free_ok_now  = free_ok_reg || !valid_reg[idx_reg];
    assign free_idx_now = free_ok_reg ? free_idx_reg : idx_reg;

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        key_next      = key_reg;
        free_ok_next  = free_ok_reg;
        free_idx_next = free_idx_reg;
        valid_next    = valid_reg;
        rsp           = '0;
        rsp.entry     = rdata;
        rsp.hit_idx   = idx_reg;
        rsp.free_ok   = free_ok_now;
        rsp.free_idx  = free_idx_now;

        if (cmd.clear)
        begin
            valid_next = '0;
        end
        if (cmd.write)
        begin
            valid_next[cmd.widx] = 1'b1;
        end

        unique case (state_reg)
            T_IDLE:
            begin
                if (cmd.lookup)
                begin
                    key_next     = cmd.key;
                    idx_next     = '0;
                    free_ok_next = 1'b0;
                    state_next   = T_ADDR;
                end
            end
            T_ADDR:
            begin
                state_next = T_CMP;
            end
            T_CMP:
            begin
                free_ok_next  = free_ok_now;
                free_idx_next = free_idx_now;
                if (hit)
                begin
                    rsp.done   = 1'b1;
                    rsp.found  = 1'b1;
                    state_next = T_IDLE;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    rsp.done   = 1'b1;
                    state_next = T_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = T_ADDR;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= T_IDLE;
            valid_reg   <= '0;
            free_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            free_ok_reg <= free_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        key_reg      <= key_next;
        free_idx_reg <= free_idx_next;
    end

endmodule

// File: hw/rtl/ll1_predictive_parser_engine_top.sv
// LL(1) table-driven recognizer. Load rule beats key a parse-table entry by
// (nonterminal, terminal); symbol beats run the stack until the symbol is
// consumed or a verdict is reached, and every input beat gives one result beat.
// Table lookups walk the 64-entry rule memory one entry at a time and stop at
// the first hit; a load waits on one search, while a clear or an unused opcode
// goes straight to its result; a symbol reads the stack top, may search the
// table and then pushes the right side one symbol at a time, and repeats;
// a verdict then rebuilds the stack in S_INIT0 and S_INIT1. After reset the
// block writes the bottom marker and start symbol before it takes a beat.
// The input side stays stalled while an item is at work, but a new item can be
// taken while the previous result still waits on the output side.
module ll1_predictive_parser_engine_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  llp_pkg::llp_in_t in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output llp_pkg::llp_out_t out_data,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import llp_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_LOAD_WAIT = 4'd1;
    localparam logic [3:0] S_TOP_RD    = 4'd2;
    localparam logic [3:0] S_TOP_CHK   = 4'd3;
    localparam logic [3:0] S_FEED_WAIT = 4'd4;
    localparam logic [3:0] S_PUSH      = 4'd5;
    localparam logic [3:0] S_INIT0     = 4'd6;
    localparam logic [3:0] S_INIT1     = 4'd7;
    localparam logic [3:0] S_DONE      = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [7:0]        exp_reg, exp_next;
    logic [7:0]        sym_reg, sym_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [63:0]       body_reg, body_next;
    logic [15:0]       key_reg, key_next;
    logic [CNT_W-1:0]  push_reg, push_next;
    logic [2:0]        status_reg, status_next;
    logic              report_reg, report_next;
    logic [7:0]        start_reg, maxexp_reg;
    llp_out_t          out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    llp_tab_cmd_t      tcmd;
    llp_tab_rsp_t      trsp;

    logic              stk_we, stk_re;
    logic [STK_AW-1:0] stk_waddr, stk_raddr;
    logic [7:0]        stk_wdata, stk_rdata;

    logic              in_acc;
    logic              cfg_wr;
    logic [LEN_W-1:0]  in_len_sat;
    logic [CNT_W-1:0]  n_push;
    logic [SP_W:0]     sp_after;
    logic [7:0]        push_sym;
    logic [BIDX_W-1:0] push_bidx;

    llp_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (tcmd),
        .rsp   (trsp)
    );

    llp_ram #(
        .WIDTH (8),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_MAXEXP) ? {24'd0, maxexp_reg} : {24'd0, start_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= 8'd83;
            maxexp_reg <= 8'd64;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_START)
            begin
                start_reg <= pwdata[7:0];
            end
            else
            begin
                maxexp_reg <= pwdata[7:0];
            end
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign in_len_sat = (in_data.rule_length > LEN_W'(RULE_MAX_LEN)) ?
                        LEN_W'(RULE_MAX_LEN) : in_data.rule_length;

    // symbols a found rule will push, '$' skipped
    always_comb
    begin
        n_push = '0;
        for (int i = 0; i < RULE_MAX_LEN; i++)
        begin
            if ((LEN_W'(i) < trsp.entry.len) && (trsp.entry.body[8*i +: 8] != END_MARK))
            begin
                n_push = n_push + 1'b1;
            end
        end
    end

    assign sp_after  = (SP_W+1)'(sp_reg) - 1'b1 + (SP_W+1)'(n_push);
    assign push_bidx = BIDX_W'(push_reg - 1'b1);
    assign push_sym  = body_reg[8*push_bidx +: 8];

    always_comb
    begin
        state_next     = state_reg;
        sp_next        = sp_reg;
        exp_next       = exp_reg;
        sym_next       = sym_reg;
        len_next       = len_reg;
        body_next      = body_reg;
        key_next       = key_reg;
        push_next      = push_reg;
        status_next    = status_reg;
        report_next    = report_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        tcmd           = '0;
        tcmd.key       = key_reg;
        tcmd.wentry    = '{key: key_reg, len: len_reg, body: body_reg};
        stk_we         = 1'b0;
        stk_waddr      = STK_AW'(sp_reg);
        stk_wdata      = push_sym;
        stk_re         = 1'b0;
        stk_raddr      = STK_AW'(sp_reg - 1'b1);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    exp_next = '0;
                    unique case (in_data.opcode)
                        OP_LOAD:
                        begin
                            key_next    = {in_data.rule_nonterminal, in_data.rule_terminal};
                            len_next    = in_len_sat;
                            body_next   = in_data.rule_body;
                            tcmd.lookup = 1'b1;
                            tcmd.key    = {in_data.rule_nonterminal, in_data.rule_terminal};
                            state_next  = S_LOAD_WAIT;
                        end
                        OP_FEED:
                        begin
                            sym_next   = in_data.symbol;
                            state_next = S_TOP_RD;
                        end
                        OP_CLEAR:
                        begin
                            tcmd.clear  = 1'b1;
                            status_next = ST_CLEARED;
                            state_next  = S_DONE;
                        end
                        default:
                        begin
                            status_next = ST_REJECTED;
                            state_next  = S_DONE;
                        end
                    endcase
                end
            end
            S_LOAD_WAIT:
            begin
                if (trsp.done)
                begin
                    if (trsp.found || trsp.free_ok)
                    begin
                        tcmd.write  = 1'b1;
                        tcmd.widx   = trsp.found ? trsp.hit_idx : trsp.free_idx;
                        status_next = ST_STORED;
                    end
                    else
                    begin
                        status_next = ST_FULL;
                    end
                    state_next = S_DONE;
                end
            end
            S_TOP_RD:
            begin
                if (sp_reg == '0)
                begin
                    status_next = ST_REJECTED;
                    report_next = 1'b1;
                    state_next  = S_INIT0;
                end
                else
                begin
                    stk_re     = 1'b1;
                    state_next = S_TOP_CHK;
                end
            end
            S_TOP_CHK:
            begin
                if (stk_rdata == END_MARK)
                begin
                    status_next = (sym_reg == END_MARK) ? ST_ACCEPTED : ST_REJECTED;
                    report_next = 1'b1;
                    state_next  = S_INIT0;
                end
                else if (stk_rdata == sym_reg)
                begin
                    sp_next     = sp_reg - 1'b1;
                    status_next = ST_CONSUMED;
                    state_next  = S_DONE;
                end
                else
                begin
                    tcmd.lookup = 1'b1;
                    tcmd.key    = {stk_rdata, sym_reg};
                    state_next  = S_FEED_WAIT;
                end
            end
            S_FEED_WAIT:
            begin
                if (trsp.done)
                begin
                    if (!trsp.found)
                    begin
                        status_next = ST_REJECTED;
                        report_next = 1'b1;
                        state_next  = S_INIT0;
                    end
                    else if (exp_reg >= maxexp_reg)
                    begin
                        status_next = ST_EXP_LIM;
                        report_next = 1'b1;
                        state_next  = S_INIT0;
                    end
                    else if (sp_after > (SP_W+1)'(STACK_DEPTH))
                    begin
                        exp_next    = exp_reg + 1'b1;
                        status_next = ST_OVERFLOW;
                        report_next = 1'b1;
                        state_next  = S_INIT0;
                    end
                    else
                    begin
                        exp_next   = exp_reg + 1'b1;
                        sp_next    = sp_reg - 1'b1;
                        body_next  = trsp.entry.body;
                        push_next  = CNT_W'(trsp.entry.len);
                        state_next = S_PUSH;
                    end
                end
            end
            S_PUSH:
            begin
                // right side goes on last symbol first
                if (push_reg == '0)
                begin
                    state_next = S_TOP_RD;
                end
                else
                begin
                    if (push_sym != END_MARK)
                    begin
                        stk_we  = 1'b1;
                        sp_next = sp_reg + 1'b1;
                    end
                    push_next = push_reg - 1'b1;
                end
            end
            S_INIT0:
            begin
                stk_we     = 1'b1;
                stk_waddr  = '0;
                stk_wdata  = END_MARK;
                state_next = S_INIT1;
            end
            S_INIT1:
            begin
                stk_we     = 1'b1;
                stk_waddr  = STK_AW'(1);
                stk_wdata  = start_reg;
                sp_next    = SP_W'(2);
                state_next = report_reg ? S_DONE : S_IDLE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_next.status          = status_reg;
                    out_next.expansions_used = exp_reg;
                    out_next.stack_level     = 7'(sp_reg);
                    out_valid_next           = 1'b1;
                    report_next              = 1'b0;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT0;
            sp_reg        <= SP_W'(2);
            report_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            report_reg    <= report_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg    <= exp_next;
        sym_reg    <= sym_next;
        len_reg    <= len_next;
        body_reg   <= body_next;
        key_reg    <= key_next;
        push_reg   <= push_next;
        status_reg <= status_next;
        out_reg    <= out_next;
    end

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH && stk_we) |-> sp_reg < SP_W'(STACK_DEPTH))
        else $error("push into a full stack");

    a_load_no_exp: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.status == ST_STORED || out_reg.status == ST_FULL
            || out_reg.status == ST_CLEARED)) |-> out_reg.expansions_used == 8'd0)
        else $error("table beat reports expansions");

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import llp_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    llp_in_t     in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b1;
    llp_out_t    out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    ll1_predictive_parser_engine_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    // predictor state
    logic [7:0]  start_sym;
    logic [7:0]  max_exp;
    logic        tab_valid [TABLE_ENTRIES];
    logic [15:0] tab_key [TABLE_ENTRIES];
    logic [3:0]  tab_len [TABLE_ENTRIES];
    logic [63:0] tab_body [TABLE_ENTRIES];
    logic [7:0]  stk [STACK_DEPTH];
    int          sp;

    llp_out_t    expected_results[$];
    int          errors = 0;
    int          mismatches = 0;
    int          n_items = 0;
    int          n_results = 0;
    int          n_accepts = 0;
    longint      cycles = 0;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 64'd3000000)
        begin
            $display("timeout at cycle %0d", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic void stack_reset();
        stk[0] = END_MARK;
        stk[1] = start_sym;
        sp = 2;
    endfunction

    function automatic int lookup_rule(logic [15:0] key);
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (tab_valid[i] && tab_key[i] == key)
                return i;
        return -1;
    endfunction

    function automatic logic [2:0] run_symbol(logic [7:0] s, output logic [7:0] used);
        int          e;
        int          cnt;
        logic [7:0]  top;
        logic [7:0]  b;
        int          nexp;
        nexp = 0;
        forever
        begin
            used = nexp[7:0];
            if (sp == 0)
            begin
                stack_reset();
                return ST_REJECTED;
            end
            top = stk[sp-1];
            if (top == END_MARK)
            begin
                stack_reset();
                return (s == END_MARK) ? ST_ACCEPTED : ST_REJECTED;
            end
            if (top == s)
            begin
                sp--;
                return ST_CONSUMED;
            end
            e = lookup_rule({top, s});
            if (e < 0)
            begin
                stack_reset();
                return ST_REJECTED;
            end
            if (nexp >= max_exp)
            begin
                stack_reset();
                return ST_EXP_LIM;
            end
            nexp++;
            used = nexp[7:0];
            cnt = 0;
            for (int i = 0; i < tab_len[e]; i++)
                if (tab_body[e][8*i +: 8] != END_MARK)
                    cnt++;
            if (sp - 1 + cnt > STACK_DEPTH)
            begin
                stack_reset();
                return ST_OVERFLOW;
            end
            sp--;
            for (int i = tab_len[e]; i > 0; i--)
            begin
                b = tab_body[e][8*(i-1) +: 8];
                if (b != END_MARK)
                begin
                    stk[sp] = b;
                    sp++;
                end
            end
        end
    endfunction

    function automatic llp_out_t predict_parse(llp_in_t it);
        llp_out_t r;
        int       e;
        logic [3:0] len;
        r = '0;
        case (it.opcode)
            OP_LOAD:
            begin
                len = (it.rule_length > RULE_MAX_LEN) ? 4'(RULE_MAX_LEN) : it.rule_length;
                e = lookup_rule({it.rule_nonterminal, it.rule_terminal});
                if (e < 0)
                    for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
                        if (!tab_valid[i])
                            e = i;
                if (e < 0)
                    r.status = ST_FULL;
                else
                begin
                    tab_valid[e] = 1'b1;
                    tab_key[e] = {it.rule_nonterminal, it.rule_terminal};
                    tab_len[e] = len;
                    tab_body[e] = it.rule_body;
                    r.status = ST_STORED;
                end
            end
            OP_FEED:
                r.status = run_symbol(it.symbol, r.expansions_used);
            OP_CLEAR:
            begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    tab_valid[i] = 1'b0;
                r.status = ST_CLEARED;
            end
            default:
                r.status = ST_REJECTED;
        endcase
        r.stack_level = sp[6:0];
        return r;
    endfunction

    // send one beat, with a random gap before it
    task automatic send_item(llp_in_t it);
        int gap;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.insert(expected_results.size(), predict_parse(it));
        if (it.opcode == OP_FEED && expected_results[$].status == ST_ACCEPTED)
            n_accepts++;
        n_items++;
    endtask

    // result checker with random receiver stalls
    initial
    begin
        int hold;
        llp_out_t exp_r;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            hold = $urandom_range(0, 11);
            if ($urandom_range(0, 3) == 0)
                hold = 0;
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            n_results++;
            if (expected_results.size() == 0)
            begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected result beat %p", out_data);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (out_data !== exp_r)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch: exp st=%0d exp=%0d lvl=%0d got st=%0d exp=%0d lvl=%0d",
                                 exp_r.status, exp_r.expansions_used, exp_r.stack_level,
                                 out_data.status, out_data.expansions_used,
                                 out_data.stack_level);
                end
            end
        end
    end

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // wait for all results, then the block's own settle time
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic set_config(logic [7:0] s, logic [7:0] m);
        drain();
        apb_write({REG_START, 2'b00}, {24'd0, s});
        apb_write({REG_MAXEXP, 2'b00}, {24'd0, m});
        start_sym = s;
        max_exp = m;
        // a verdict rebuilds with the new start symbol; force one
        feed(END_MARK);
        feed(END_MARK);
        drain();
    endtask

    function automatic llp_in_t rand_item();
        llp_in_t it;
        it = '0;
        it.opcode = 2'($urandom_range(0, 3));
        it.symbol = 8'($urandom);
        it.rule_nonterminal = 8'($urandom);
        it.rule_terminal = 8'($urandom);
        it.rule_length = 4'($urandom);
        it.rule_body = {$urandom, $urandom};
        return it;
    endfunction

    task automatic load_rule(logic [7:0] nt, logic [7:0] t, logic [3:0] len,
                             logic [63:0] body);
        llp_in_t it;
        it = rand_item();
        it.opcode = OP_LOAD;
        it.rule_nonterminal = nt;
        it.rule_terminal = t;
        it.rule_length = len;
        it.rule_body = body;
        send_item(it);
    endtask

    task automatic feed(logic [7:0] s);
        llp_in_t it;
        it = rand_item();
        it.opcode = OP_FEED;
        it.symbol = s;
        send_item(it);
    endtask

    task automatic clear_table();
        llp_in_t it;
        it = rand_item();
        it.opcode = OP_CLEAR;
        send_item(it);
    endtask

    // grammar S -> a S b | '$'-padded empty, over a and b
    task automatic load_anbn(logic [7:0] s_sym);
        load_rule(s_sym, "a", 4'd3, {40'h0, "b", s_sym, "a"});
        load_rule(s_sym, "b", 4'd1, {56'h0, END_MARK});
        load_rule(s_sym, END_MARK, 4'd0, 64'h0);
    endtask

    task automatic test_directed();
        llp_in_t it;
        load_anbn(8'd83);
        feed("a"); feed("a"); feed("b"); feed("b"); feed(END_MARK);
        feed("b");                       // S -> empty, then rejected at the bottom marker
        feed(END_MARK); feed("x");       // accepted, then x has no rule
        load_rule(8'd83, "a", 4'd15, {"b", 8'd83, "a", 8'd36, "c", "c", "c", "c"});
        load_rule(8'd83, "a", 4'd3, {40'h0, "b", 8'd83, "a"});  // overwrite
        it = rand_item();
        it.opcode = OP_RSVD;
        send_item(it);
        load_rule(8'hFF, 8'h00, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
        load_rule(8'h00, 8'hFF, 4'd0, 64'h0);
        feed(8'hFF); feed(8'h00);
        clear_table();
        feed("a");
    endtask

    task automatic test_limits();
        // left recursion S -> S S hits the expansion limit or overflows
        set_config(8'd83, 8'd1);
        load_rule(8'd83, "z", 4'd2, {48'h0, 8'd83, 8'd83});
        feed("z");
        set_config(8'd83, 8'd255);
        feed("z");
        load_rule(8'd83, "y", 4'd8, {8{8'd83}});
        feed("y");
        set_config(8'd0, 8'd64);
        load_rule(8'd0, "q", 4'd0, 64'h0);
        feed("q"); feed(END_MARK);
        clear_table();
    endtask

    task automatic test_table_full();
        for (int i = 0; i < TABLE_ENTRIES + 2; i++)
            load_rule(8'(i), 8'(i * 7), 4'($urandom), {$urandom, $urandom});
        load_rule(8'd3, 8'd21, 4'd2, 64'h0);   // existing key still fits
        clear_table();
    endtask

    task automatic test_random();
        logic [7:0] s_sym;
        int depth;
        for (int phase = 0; phase < 4; phase++)
        begin
            s_sym = (phase == 3) ? 8'hFF : 8'($urandom_range(65, 90));
            set_config(s_sym, (phase == 2) ? 8'd255 : 8'($urandom_range(2, 80)));
            clear_table();
            load_anbn(s_sym);
            for (int k = 0; k < 14; k++)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    depth = $urandom_range(0, 6);
                    repeat (depth) feed("a");
                    if ($urandom_range(0, 4) == 0)
                        depth = depth + $urandom_range(0, 2) - 1;
                    if (depth < 0)
                        depth = 0;
                    repeat (depth) feed("b");
                    feed(($urandom_range(0, 5) == 0) ? 8'($urandom) : END_MARK);
                end
                else if ($urandom_range(0, 1))
                    send_item(rand_item());
                else
                    load_rule(s_sym, 8'($urandom_range(97, 100)), 4'($urandom_range(0, 4)),
                              {$urandom, $urandom});
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            tab_valid[i] = 1'b0;
            tab_key[i] = '0;
            tab_len[i] = '0;
            tab_body[i] = '0;
        end
        start_sym = 8'd83;
        max_exp = 8'd64;
        stack_reset();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_limits();
        test_table_full();
        test_random();
        drain();
        $display("sent %0d beats, checked %0d results, %0d strings accepted",
                 n_items, n_results, n_accepts);
        $display("covered loads, overwrite, table full, clear, limits, overflow, random strings");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
